FILE: rtl/flm3_pkg.sv
// Shared types and constants of the first local maximum 3x3 block.
package flm3_pkg;

	localparam int VAL_W     = 32;
	localparam int SUM_W     = 48;
	localparam int ROW_W     = 12;
	localparam int COL_CFG_W = 8;
	localparam int COL_OUT_W = 7;
	localparam int CFG_IDX_W = 4;
	localparam int CFG_DAT_W = 12;

	localparam logic [CFG_IDX_W-1:0] REG_ROW_COUNT    = 4'd0;
	localparam logic [CFG_IDX_W-1:0] REG_COLUMN_COUNT = 4'd1;

	localparam logic signed [SUM_W-1:0] SUM_MAX = 48'sh7FFF_FFFF_FFFF;
	localparam logic signed [SUM_W-1:0] SUM_MIN = 48'sh8000_0000_0000;

	// Result buffer depth and the width of its fill count.
	localparam int OUT_DEPTH = 4;
	localparam int OUT_CNT_W = 3;

	typedef struct packed {
		logic                    found;
		logic [ROW_W-1:0]        max_row;
		logic [COL_OUT_W-1:0]    max_column;
		logic signed [VAL_W-1:0] max_value;
		logic signed [SUM_W-1:0] checked_sum;
	} result_t;

endpackage

FILE: rtl/first_local_maximum_3x3_top.sv
// Top level: raster 3x3 first strict local maximum finder with saturating sum.
//
//  channel | direction | handshake             | payload
//  --------+-----------+-----------------------+-----------------------------------------
//  cfg     | in        | cfg_valid / cfg_ready | cfg_index, cfg_data
//  in      | in        | in_valid / in_ready   | cell_value
//  out     | out       | out_valid / out_ready | found, max_row, max_column, max_value,
//          |           |                       | checked_sum
//
// One element is taken per cycle while in_ready is high; the line store RAM is read at acceptance and
// written back in the next cycle, with forwarding when consecutive beats hit one column.
// The result of a matrix passes through stage 1, stage 2 and the result buffer after its last element.
// After reset the line store is cleared, one column a cycle, across all MAX_COLUMNS columns;
// in_ready stays low then, while configuration writes are taken at once.
// A four-entry result buffer absorbs output stalls; in_ready drops on a last
// element only when that buffer could not hold its result.
module first_local_maximum_3x3_top
	import flm3_pkg::*;
#(
	parameter int MAX_COLUMNS = 128
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    cfg_valid,
	output logic                    cfg_ready,
	input  logic [CFG_IDX_W-1:0]    cfg_index,
	input  logic [CFG_DAT_W-1:0]    cfg_data,
	input  logic                    in_valid,
	output logic                    in_ready,
	input  logic signed [VAL_W-1:0] cell_value,
	output logic                    out_valid,
	input  logic                    out_ready,
	output logic                    found,
	output logic [ROW_W-1:0]        max_row,
	output logic [COL_OUT_W-1:0]    max_column,
	output logic signed [VAL_W-1:0] max_value,
	output logic signed [SUM_W-1:0] checked_sum
);

	localparam int CW = $clog2(MAX_COLUMNS);
	localparam int KW = ((CW > COL_CFG_W) ? CW : COL_CFG_W) + 1;
	localparam int LW = 2 * VAL_W;

	// Configuration registers.
	logic [ROW_W-1:0]     row_count_q;
	logic [COL_CFG_W-1:0] column_count_q;

	// Raster position and the clearing pass.
	logic [ROW_W-1:0] row_q;
	logic [CW-1:0]    col_q;
	logic             clr_q;
	logic [CW-1:0]    clr_addr_q;

	logic [ROW_W-1:0] rows_eff;
	logic [KW-1:0]    col_req;
	logic [KW-1:0]    cols_eff;
	logic             end_row_now;
	logic             end_mat_now;
	logic             cand_now;
	logic             in_acc;

	// Stage 1: line store data returns.
	logic                    s1_valid_q;
	logic signed [VAL_W-1:0] v_s1;
	logic [ROW_W-1:0]        row_s1;
	logic [CW-1:0]           col_s1;
	logic                    cand_s1;
	logic                    end_s1;
	logic                    fwd_q;
	logic [LW-1:0]           fwd_data_q;
	logic [LW-1:0]           rd_data;
	logic [LW-1:0]           line;
	logic signed [VAL_W-1:0] top;
	logic signed [VAL_W-1:0] mid;
	logic signed [VAL_W-1:0] centre;
	logic                    peak;

	// Two older window columns: index 0 is the oldest row.
	logic signed [VAL_W-1:0] prev_col_q [3];
	logic signed [VAL_W-1:0] new_col_q  [3];

	// RAM ports.
	logic          ram_we;
	logic [CW-1:0] ram_waddr;
	logic [LW-1:0] ram_wdata;

	// Stage 2: per-matrix bookkeeping.
	logic                    s2_valid_q;
	logic signed [VAL_W-1:0] centre_s2;
	logic                    peak_s2;
	logic                    cand_s2;
	logic                    end_s2;
	logic [ROW_W-1:0]        row_s2;
	logic [CW-1:0]           col_s2;

	logic                    found_q;
	logic [ROW_W-1:0]        frow_q;
	logic [CW-1:0]           fcol_q;
	logic signed [VAL_W-1:0] fval_q;
	logic signed [SUM_W-1:0] sum_q;

	logic                    chk;
	logic                    hit;
	logic signed [SUM_W:0]   sum_ext;
	logic signed [SUM_W-1:0] sum_n;
	logic                    found_n;
	logic [ROW_W-1:0]        frow_n;
	logic [CW-1:0]           fcol_n;
	logic signed [VAL_W-1:0] fval_n;

	logic                 push;
	result_t              push_data;
	result_t              head;
	logic [OUT_CNT_W-1:0] fifo_count;
	logic [OUT_CNT_W:0]   reserved;

	// ------------------------------------------------------------------
	// Configuration
	// ------------------------------------------------------------------
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_count_q    <= ROW_W'(3);
			column_count_q <= COL_CFG_W'(3);
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_ROW_COUNT:    row_count_q    <= cfg_data[ROW_W-1:0];
				REG_COLUMN_COUNT: column_count_q <= cfg_data[COL_CFG_W-1:0];
				default: ;
			endcase
		end
	end

	// ------------------------------------------------------------------
	// Stage 0: position tracking and acceptance
	// ------------------------------------------------------------------
	always_comb begin
		rows_eff    = (row_count_q == '0) ? ROW_W'(1) : row_count_q;
		col_req     = (column_count_q == '0) ? KW'(1) : KW'(column_count_q);
		cols_eff    = (col_req > KW'(MAX_COLUMNS)) ? KW'(MAX_COLUMNS) : col_req;
		end_row_now = (KW'(col_q) + KW'(1)) >= cols_eff;
		end_mat_now = end_row_now &&
			(({1'b0, row_q} + (ROW_W + 1)'(1)) >= {1'b0, rows_eff});
		cand_now    = (row_q >= ROW_W'(2)) && (col_q >= CW'(2));
	end

	// Results already owed to the buffer, counting those still in the pipeline.
	assign reserved = (OUT_CNT_W + 1)'(fifo_count)
		+ (OUT_CNT_W + 1)'(s1_valid_q && end_s1)
		+ (OUT_CNT_W + 1)'(s2_valid_q && end_s2);

	assign in_ready = !clr_q && (!end_mat_now || (reserved < (OUT_CNT_W + 1)'(OUT_DEPTH)));
	assign in_acc   = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q      <= '0;
			col_q      <= '0;
			clr_q      <= 1'b1;
			clr_addr_q <= '0;
		end else begin
			if (clr_q) begin
				clr_addr_q <= clr_addr_q + CW'(1);
				if (clr_addr_q == CW'(MAX_COLUMNS - 1)) begin
					clr_q <= 1'b0;
				end
			end
			if (in_acc) begin
				if (end_mat_now) begin
					row_q <= '0;
					col_q <= '0;
				end else if (end_row_now) begin
					row_q <= row_q + ROW_W'(1);
					col_q <= '0;
				end else begin
					col_q <= col_q + CW'(1);
				end
			end
		end
	end

	// ------------------------------------------------------------------
	// Line store: each word holds {older row, newer row} of one column.
	// ------------------------------------------------------------------
	assign ram_we    = clr_q || s1_valid_q;
	assign ram_waddr = clr_q ? clr_addr_q : col_s1;
	assign ram_wdata = clr_q ? '0 : {mid, v_s1};

	flm3_ram #(
		.WIDTH (LW),
		.DEPTH (MAX_COLUMNS)
	) u_line_store (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (in_acc),
		.raddr (col_q),
		.rdata (rd_data)
	);

	// ------------------------------------------------------------------
	// Stage 1: window update and neighbour compares
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
			fwd_q      <= 1'b0;
		end else begin
			s1_valid_q <= in_acc;
			// The column being written this cycle is the one just read.
			fwd_q      <= in_acc && s1_valid_q && (col_s1 == col_q);
		end
	end

	always_ff @(posedge clk) begin
		fwd_data_q <= ram_wdata;
		if (in_acc) begin
			v_s1    <= cell_value;
			row_s1  <= row_q;
			col_s1  <= col_q;
			cand_s1 <= cand_now;
			end_s1  <= end_mat_now;
		end
	end

	always_comb begin
		line   = fwd_q ? fwd_data_q : rd_data;
		top    = line[LW-1:VAL_W];
		mid    = line[VAL_W-1:0];
		centre = new_col_q[1];
		peak   = (prev_col_q[0] < centre) && (prev_col_q[1] < centre)
			&& (prev_col_q[2] < centre) && (new_col_q[0] < centre)
			&& (new_col_q[2] < centre) && (top < centre)
			&& (mid < centre) && (v_s1 < centre);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 3; i++) begin
				prev_col_q[i] <= '0;
				new_col_q[i]  <= '0;
			end
		end else if (s1_valid_q) begin
			for (int i = 0; i < 3; i++) begin
				prev_col_q[i] <= new_col_q[i];
			end
			new_col_q[0] <= top;
			new_col_q[1] <= mid;
			new_col_q[2] <= v_s1;
		end
	end

	// ------------------------------------------------------------------
	// Stage 2: running sum, first maximum and result hand-off
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s2_valid_q <= 1'b0;
		end else begin
			s2_valid_q <= s1_valid_q;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_valid_q) begin
			centre_s2 <= centre;
			peak_s2   <= peak;
			cand_s2   <= cand_s1;
			end_s2    <= end_s1;
			row_s2    <= row_s1;
			col_s2    <= col_s1;
		end
	end

	always_comb begin
		chk     = s2_valid_q && cand_s2 && !found_q;
		hit     = chk && peak_s2;
		sum_ext = {sum_q[SUM_W-1], sum_q} + (SUM_W + 1)'(centre_s2);
		if (!chk) begin
			sum_n = sum_q;
		end else if (sum_ext[SUM_W] != sum_ext[SUM_W-1]) begin
			sum_n = sum_ext[SUM_W] ? SUM_MIN : SUM_MAX;
		end else begin
			sum_n = sum_ext[SUM_W-1:0];
		end
		found_n = found_q || hit;
		frow_n  = hit ? row_s2 - ROW_W'(1) : frow_q;
		fcol_n  = hit ? col_s2 - CW'(1) : fcol_q;
		fval_n  = hit ? centre_s2 : fval_q;

		push                  = s2_valid_q && end_s2;
		push_data.found       = found_n;
		push_data.max_row     = frow_n;
		push_data.max_column  = COL_OUT_W'(fcol_n);
		push_data.max_value   = fval_n;
		push_data.checked_sum = sum_n;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			found_q <= 1'b0;
			frow_q  <= '0;
			fcol_q  <= '0;
			fval_q  <= '0;
			sum_q   <= '0;
		end else if (s2_valid_q) begin
			if (end_s2) begin
				found_q <= 1'b0;
				frow_q  <= '0;
				fcol_q  <= '0;
				fval_q  <= '0;
				sum_q   <= '0;
			end else begin
				found_q <= found_n;
				frow_q  <= frow_n;
				fcol_q  <= fcol_n;
				fval_q  <= fval_n;
				sum_q   <= sum_n;
			end
		end
	end

	flm3_out_fifo #(
		.DEPTH (OUT_DEPTH)
	) u_out_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.pop       (out_valid && out_ready),
		.out_valid (out_valid),
		.out_data  (head),
		.count     (fifo_count)
	);

	assign found       = head.found;
	assign max_row     = head.max_row;
	assign max_column  = head.max_column;
	assign max_value   = head.max_value;
	assign checked_sum = head.checked_sum;

`ifndef SYNTH
	// Results owed can never exceed the buffer.
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		reserved <= (OUT_CNT_W + 1)'(OUT_DEPTH))
		else $error("result buffer overcommitted");

	// A finished matrix always leaves a result waiting.
	a_result_lands: assert property (@(posedge clk) disable iff (!arst_n)
		(s2_valid_q && end_s2) |=> out_valid)
		else $error("result of a finished matrix was lost");

	// Once found, the maximum sticks until the matrix ends.
	a_found_sticks: assert property (@(posedge clk) disable iff (!arst_n)
		(found_q && !(s2_valid_q && end_s2)) |=> found_q)
		else $error("found flag dropped inside a matrix");

	// The line store sweep never overlaps element traffic.
	a_clear_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		clr_q |-> !s1_valid_q)
		else $error("element in flight during line store clearing");
`endif

endmodule

FILE: rtl/flm3_ram.sv
// Generic single-clock RAM with one write port and one registered read port.
module flm3_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 128
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

FILE: rtl/flm3_out_fifo.sv
// Small register FIFO that holds finished results until the consumer takes them.
module flm3_out_fifo
	import flm3_pkg::*;
#(
	parameter int DEPTH = 4
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	input  result_t              push_data,
	input  logic                 pop,
	output logic                 out_valid,
	output result_t              out_data,
	output logic [OUT_CNT_W-1:0] count
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	result_t           entry_q [DEPTH];
	logic [PW-1:0]     wptr_q;
	logic [PW-1:0]     rptr_q;
	logic [OUT_CNT_W-1:0] count_q;

	assign out_valid = (count_q != '0);
	assign out_data  = entry_q[rptr_q];
	assign count     = count_q;

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= '0;
			rptr_q  <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wptr_q <= (wptr_q == PW'(DEPTH - 1)) ? '0 : wptr_q + PW'(1);
			end
			if (pop) begin
				rptr_q <= (rptr_q == PW'(DEPTH - 1)) ? '0 : rptr_q + PW'(1);
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + OUT_CNT_W'(1);
				2'b01:   count_q <= count_q - OUT_CNT_W'(1);
				default: count_q <= count_q;
			endcase
		end
	end

endmodule
